@@ hw/rtl/pmks_pkg.sv @@
// ----------------------------------------------------------------------------
// pmks_pkg
// Shared types and constants for the profile most-probable k-mer scanner.
// ----------------------------------------------------------------------------
package pmks_pkg;

  localparam int K_MAX_DEF     = 16;
  localparam int POS_WIDTH_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int ROW_W   = 2;
  localparam int COL_W   = 4;
  localparam int ENTRY_W = 16;
  localparam int CHAR_W  = 8;
  localparam int COST_W  = 20;
  localparam int KCFG_W  = 5;
  localparam int OPOS_W  = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

  // Cost value that marks a zero-probability profile entry
  localparam logic [ENTRY_W-1:0] COST_NONE = 16'hFFFF;
  localparam logic [COST_W-1:0]  COST_SAT  = 20'hFFFFF;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  localparam logic [ROW_W-1:0] ROW_A = 2'd0;
  localparam logic [ROW_W-1:0] ROW_C = 2'd1;
  localparam logic [ROW_W-1:0] ROW_G = 2'd2;
  localparam logic [ROW_W-1:0] ROW_T = 2'd3;

  typedef enum logic [0:0] {
    ST_SCAN,
    ST_EMIT
  } st_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic               load_en;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [ENTRY_W-1:0] entry;
    logic               shift_en;
    logic [CHAR_W-1:0]  text_char;
    logic               capture;
  } cell_ctl_t;

  typedef struct packed {
    logic              have;
    logic              zero_prob;
    logic [COST_W-1:0] total;
  } best_stat_t;

endpackage

@@ hw/rtl/pmks_cell.sv @@
// ----------------------------------------------------------------------------
// pmks_cell
// One window column: holds its profile column, accumulates the open window
// cost handed from the left neighbor, shifts the text byte along.
// ----------------------------------------------------------------------------
module pmks_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  pmks_pkg::cell_ctl_t           ctl,
  input  logic [pmks_pkg::COST_W-1:0]   prev_cost,
  input  logic                          prev_imp,
  input  logic [pmks_pkg::CHAR_W-1:0]   prev_char,
  output logic [pmks_pkg::COST_W-1:0]   cost_r,
  output logic                          imp_r,
  output logic [pmks_pkg::CHAR_W-1:0]   char_r,
  output logic [pmks_pkg::CHAR_W-1:0]   best_char_r
);

  logic [pmks_pkg::ENTRY_W-1:0] prof_r [4];
  logic [pmks_pkg::ROW_W-1:0]   row;
  logic                         hit;
  logic [pmks_pkg::ENTRY_W-1:0] entry;
  logic                         imp_add;
  logic [pmks_pkg::ENTRY_W-1:0] add;
  logic [pmks_pkg::COST_W:0]    sum;
  logic [pmks_pkg::COST_W-1:0]  cost_nxt;

  always_comb begin
    hit = 1'b1;
    row = pmks_pkg::ROW_A;
    case (ctl.text_char)
      pmks_pkg::CHAR_A: row = pmks_pkg::ROW_A;
      pmks_pkg::CHAR_C: row = pmks_pkg::ROW_C;
      pmks_pkg::CHAR_G: row = pmks_pkg::ROW_G;
      pmks_pkg::CHAR_T: row = pmks_pkg::ROW_T;
      default:          hit = 1'b0;
    endcase
  end

  assign entry    = prof_r[row];
  assign imp_add  = hit && (entry == pmks_pkg::COST_NONE);
  assign add      = (hit && !imp_add) ? entry : '0;
  assign sum      = {1'b0, prev_cost} + (pmks_pkg::COST_W+1)'(add);
  assign cost_nxt = sum[pmks_pkg::COST_W] ? pmks_pkg::COST_SAT : sum[pmks_pkg::COST_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load_en && (32'(ctl.column) == CELL_IDX)) begin
      prof_r[ctl.row] <= ctl.entry;
    end
    if (ctl.shift_en) begin
      cost_r <= cost_nxt;
      imp_r  <= prev_imp || imp_add;
      char_r <= prev_char;
    end
    if (ctl.capture) begin
      best_char_r <= char_r;
    end
  end

endmodule

@@ hw/rtl/pmks_best.sv @@
// ----------------------------------------------------------------------------
// pmks_best
// Ranks each completed window against the best so far and keeps the winner.
// ----------------------------------------------------------------------------
module pmks_best #(
  parameter int POS_WIDTH = pmks_pkg::POS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         cand_valid,
  input  logic [pmks_pkg::COST_W-1:0]  cand_cost,
  input  logic                         cand_imp,
  input  logic [POS_WIDTH-1:0]         cand_start,
  output logic                         capture,
  output pmks_pkg::best_stat_t         stat,
  output logic [POS_WIDTH-1:0]         best_start_r
);

  logic                        have_r;
  logic                        zero_r;
  logic [pmks_pkg::COST_W-1:0] total_r;
  logic                        wins;

  // possible beats impossible, lower cost wins, later window wins a tie
  assign wins    = !have_r || zero_r || (!cand_imp && (cand_cost <= total_r));
  assign capture = cand_valid && wins;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (clear) begin
      have_r <= 1'b0;
    end else if (capture) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      zero_r       <= cand_imp;
      total_r      <= cand_cost;
      best_start_r <= cand_start;
    end
  end

  assign stat.have      = have_r;
  assign stat.zero_prob = zero_r;
  assign stat.total     = total_r;

endmodule

@@ hw/rtl/profile_most_probable_kmer_scan_unit.sv @@
// ----------------------------------------------------------------------------
// profile_most_probable_kmer_scan_unit
// Profile most-probable k-mer scan over a streamed DNA text.
// ----------------------------------------------------------------------------
// Throughput: one text or load beat per cycle while the input is not stalled;
//   the K_MAX cell chain updates every open window together on each text beat.
// Results: the first result beat follows the accepted end-of-text beat in the
//   next cycle; beats drain at one per cycle while out_stall is low (k beats,
//   or 1 when no window existed), the input stalled until the last is taken.
// Reset: synchronous; control state clears and k returns to 1; profile entries
//   are undefined until loaded.
module profile_most_probable_kmer_scan_unit #(
  parameter int K_MAX     = pmks_pkg::K_MAX_DEF,
  parameter int POS_WIDTH = pmks_pkg::POS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            cfg_wr_en,
  input  logic [pmks_pkg::KCFG_W-1:0]     cfg_wr_data,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pmks_pkg::CMD_W-1:0]      in_cmd,
  input  logic [pmks_pkg::ROW_W-1:0]      in_base_row,
  input  logic [pmks_pkg::COL_W-1:0]      in_column,
  input  logic [pmks_pkg::ENTRY_W-1:0]    in_entry_cost,
  input  logic [pmks_pkg::CHAR_W-1:0]     in_text_char,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic [pmks_pkg::OPOS_W-1:0]     out_start_position,
  output logic [pmks_pkg::COST_W-1:0]     out_best_cost,
  output logic                            out_best_impossible,
  output logic [pmks_pkg::CHAR_W-1:0]     out_window_char,
  output logic                            out_last
);

  localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int KW = $clog2(K_MAX + 1);

  pmks_pkg::st_t st_r, st_nxt;

  logic [KW-1:0]        k_eff_r, k_eff_nxt;
  logic [IW-1:0]        k_last_r;
  logic [KW-1:0]        fill_r, fill_nxt;
  logic [POS_WIDTH-1:0] seen_r;
  logic                 pend_r;
  logic [POS_WIDTH-1:0] pend_start_r;
  logic [IW-1:0]        cnt_r, cnt_nxt;

  logic in_acc, out_acc, clear_run, char_acc;
  pmks_pkg::cell_ctl_t  ctl;
  pmks_pkg::best_stat_t stat;
  logic                 capture;
  logic [POS_WIDTH-1:0] best_start;

  logic [pmks_pkg::COST_W-1:0] cost_q [K_MAX];
  logic                        imp_q  [K_MAX];
  logic [pmks_pkg::CHAR_W-1:0] char_q [K_MAX];
  logic [pmks_pkg::CHAR_W-1:0] bchar_q[K_MAX];

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign char_acc  = in_acc && (in_cmd == pmks_pkg::CMD_CHAR);
  assign clear_run = cfg_wr_en || (out_acc && out_last);

  // clamp k into 1..K_MAX
  always_comb begin
    if (cfg_wr_data == '0) begin
      k_eff_nxt = KW'(1);
    end else if (32'(cfg_wr_data) > K_MAX) begin
      k_eff_nxt = KW'(K_MAX);
    end else begin
      k_eff_nxt = KW'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_eff_r  <= KW'(1);
      k_last_r <= '0;
    end else if (cfg_wr_en) begin
      k_eff_r  <= k_eff_nxt;
      k_last_r <= IW'(k_eff_nxt - KW'(1));
    end
  end

  assign fill_nxt = (fill_r < KW'(K_MAX)) ? fill_r + KW'(1) : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      seen_r <= '0;
      pend_r <= 1'b0;
    end else if (clear_run) begin
      fill_r <= '0;
      seen_r <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= char_acc && (fill_nxt >= k_eff_r);
      if (char_acc) begin
        fill_r <= fill_nxt;
        seen_r <= seen_r + POS_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_acc) begin
      pend_start_r <= seen_r - POS_WIDTH'(k_last_r);
    end
  end

  // Cell chain
  assign ctl.load_en   = in_acc && (in_cmd == pmks_pkg::CMD_LOAD);
  assign ctl.row       = in_base_row;
  assign ctl.column    = in_column;
  assign ctl.entry     = in_entry_cost;
  assign ctl.shift_en  = char_acc;
  assign ctl.text_char = in_text_char;
  assign ctl.capture   = capture;

  for (genvar j = 0; j < K_MAX; j++) begin : g_cell
    logic [pmks_pkg::COST_W-1:0] p_cost;
    logic                        p_imp;
    logic [pmks_pkg::CHAR_W-1:0] p_char;
    if (j == 0) begin : g_head
      assign p_cost = '0;
      assign p_imp  = 1'b0;
      assign p_char = in_text_char;
    end else begin : g_link
      assign p_cost = cost_q[j-1];
      assign p_imp  = imp_q[j-1];
      assign p_char = char_q[j-1];
    end
    pmks_cell #(
      .CELL_IDX (j)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .prev_cost   (p_cost),
      .prev_imp    (p_imp),
      .prev_char   (p_char),
      .cost_r      (cost_q[j]),
      .imp_r       (imp_q[j]),
      .char_r      (char_q[j]),
      .best_char_r (bchar_q[j])
    );
  end

  // Window completed last cycle is read from chain cell k-1 and ranked against the best so far
  pmks_best #(
    .POS_WIDTH (POS_WIDTH)
  ) u_best (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (clear_run),
    .cand_valid   (pend_r),
    .cand_cost    (cost_q[k_last_r]),
    .cand_imp     (imp_q[k_last_r]),
    .cand_start   (pend_start_r),
    .capture      (capture),
    .stat         (stat),
    .best_start_r (best_start)
  );

  // Result sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pmks_pkg::ST_SCAN: begin
        if (in_acc && (in_cmd == pmks_pkg::CMD_END)) st_nxt = pmks_pkg::ST_EMIT;
      end
      pmks_pkg::ST_EMIT: begin
        if (out_acc && out_last) st_nxt = pmks_pkg::ST_SCAN;
      end
      default: st_nxt = pmks_pkg::ST_SCAN;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (st_r == pmks_pkg::ST_SCAN) begin
      cnt_nxt = k_last_r;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pmks_pkg::ST_SCAN;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  // oldest byte sits in cell k-1, so the count runs down to cell 0
  always_comb begin
    in_stall            = (st_r != pmks_pkg::ST_SCAN);
    out_valid           = (st_r == pmks_pkg::ST_EMIT);
    out_found           = stat.have;
    out_start_position  = stat.have ? pmks_pkg::OPOS_W'(best_start) : '0;
    out_best_cost       = (stat.have && !stat.zero_prob) ? stat.total : '0;
    out_best_impossible = stat.have && stat.zero_prob;
    out_window_char     = stat.have ? bchar_q[cnt_r] : '0;
    out_last            = !stat.have || (cnt_r == '0);
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the profile most-probable k-mer scanner. Loads a profile, runs a
// short table of hand-checked texts, then random texts under several window
// lengths and idle/stall mixes. Every result beat is checked field by field
// against its table row or a behavioral scan model fed the accepted input beats.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [pmks_pkg::CMD_W-1:0] CMD_NOP = 2'd3;  // unused opcode, block ignores it
  localparam int KMAX = pmks_pkg::K_MAX_DEF;
  localparam int N_PHASE = 8;
  localparam int PHASE_ITEMS = 16;

  typedef struct packed {
    logic                        found;
    logic [pmks_pkg::OPOS_W-1:0] start;
    logic [pmks_pkg::COST_W-1:0] cost;
    logic                        dead;
    logic [pmks_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } kmer_beat_t;

  typedef struct {
    logic [pmks_pkg::CMD_W-1:0]   cmd;
    logic [pmks_pkg::ROW_W-1:0]   row;
    logic [pmks_pkg::COL_W-1:0]   col;
    logic [pmks_pkg::ENTRY_W-1:0] cost;
    logic [pmks_pkg::CHAR_W-1:0]  ch;
    bit                           typed;
    kmer_beat_t                   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [pmks_pkg::KCFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [pmks_pkg::CMD_W-1:0] in_cmd = CMD_NOP;
  logic [pmks_pkg::ROW_W-1:0] in_base_row = '0;
  logic [pmks_pkg::COL_W-1:0] in_column = '0;
  logic [pmks_pkg::ENTRY_W-1:0] in_entry_cost = '0;
  logic [pmks_pkg::CHAR_W-1:0] in_text_char = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic [pmks_pkg::OPOS_W-1:0] out_start_position;
  logic [pmks_pkg::COST_W-1:0] out_best_cost;
  logic out_best_impossible;
  logic [pmks_pkg::CHAR_W-1:0] out_window_char;
  logic out_last;

  always #5 clk = ~clk;

  profile_most_probable_kmer_scan_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_base_row        (in_base_row),
    .in_column          (in_column),
    .in_entry_cost      (in_entry_cost),
    .in_text_char       (in_text_char),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_start_position (out_start_position),
    .out_best_cost      (out_best_cost),
    .out_best_impossible(out_best_impossible),
    .out_window_char    (out_window_char),
    .out_last           (out_last)
  );

  // ---------------------------------------------------------------- scan model
  logic [pmks_pkg::ENTRY_W-1:0] prof_cost [4*KMAX];
  logic [pmks_pkg::CHAR_W-1:0]  win_byte [KMAX];
  logic [pmks_pkg::COST_W-1:0]  acc_cost [KMAX];
  bit                           acc_dead [KMAX];
  logic [pmks_pkg::CHAR_W-1:0]  top_bytes [KMAX];
  logic [pmks_pkg::COST_W-1:0]  top_cost;
  bit                           top_dead;
  logic [pmks_pkg::OPOS_W-1:0]  top_start;
  bit                           top_valid;
  logic [pmks_pkg::OPOS_W-1:0]  n_bytes;
  int                           n_fill;
  logic [pmks_pkg::KCFG_W-1:0]  k_reg;

  kmer_beat_t kmer_expect_q [$];
  kmer_beat_t fresh_beats [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int out_stall_pct = 0;

  function automatic int eff_k();
    if (k_reg == 0) return 1;
    if (k_reg > KMAX) return KMAX;
    return int'(k_reg);
  endfunction

  function automatic void clear_scan();
    for (int j = 0; j < KMAX; j++) begin
      win_byte[j] = '0;
      acc_cost[j] = '0;
      acc_dead[j] = 1'b0;
      top_bytes[j] = '0;
    end
    top_cost = '0;
    top_dead = 1'b0;
    top_start = '0;
    top_valid = 1'b0;
    n_bytes = '0;
    n_fill = 0;
  endfunction

  // returns 1 when the byte hits a zero-probability entry; cost goes to add
  function automatic bit byte_score(input logic [pmks_pkg::CHAR_W-1:0] c, input int col,
                                    output int unsigned add);
    int r;
    add = 0;
    case (c)
      pmks_pkg::CHAR_A: r = int'(pmks_pkg::ROW_A);
      pmks_pkg::CHAR_C: r = int'(pmks_pkg::ROW_C);
      pmks_pkg::CHAR_G: r = int'(pmks_pkg::ROW_G);
      pmks_pkg::CHAR_T: r = int'(pmks_pkg::ROW_T);
      default: return 1'b0;
    endcase
    if (prof_cost[r*KMAX + col] == pmks_pkg::COST_NONE) return 1'b1;
    add = 32'(prof_cost[r*KMAX + col]);
    return 1'b0;
  endfunction

  function automatic void scan_beat(input logic [pmks_pkg::CMD_W-1:0] c,
                                    input logic [pmks_pkg::ROW_W-1:0] r,
                                    input logic [pmks_pkg::COL_W-1:0] col,
                                    input logic [pmks_pkg::ENTRY_W-1:0] e,
                                    input logic [pmks_pkg::CHAR_W-1:0] ch);
    int k;
    int unsigned add;
    int unsigned s;
    bit imp;
    bit wins;
    kmer_beat_t b;
    k = eff_k();
    case (c)
      pmks_pkg::CMD_LOAD: prof_cost[int'(r)*KMAX + int'(col)] = e;
      pmks_pkg::CMD_CHAR: begin
        for (int j = k - 1; j >= 1; j--) begin
          imp = byte_score(ch, j, add);
          s = 32'(acc_cost[j-1]) + add;
          acc_cost[j] = (s > 32'(pmks_pkg::COST_SAT)) ? pmks_pkg::COST_SAT
                                                      : s[pmks_pkg::COST_W-1:0];
          acc_dead[j] = acc_dead[j-1] || imp;
          win_byte[j] = win_byte[j-1];
        end
        imp = byte_score(ch, 0, add);
        acc_cost[0] = add[pmks_pkg::COST_W-1:0];
        acc_dead[0] = imp;
        win_byte[0] = ch;
        if (n_fill < KMAX) n_fill++;
        if (n_fill >= k) begin
          if (!top_valid || top_dead) wins = 1'b1;
          else wins = !acc_dead[k-1] && acc_cost[k-1] <= top_cost;
          if (wins) begin
            top_valid = 1'b1;
            top_cost = acc_cost[k-1];
            top_dead = acc_dead[k-1];
            top_start = n_bytes - pmks_pkg::OPOS_W'(k - 1);
            for (int j = 0; j < k; j++) top_bytes[j] = win_byte[k-1-j];
          end
        end
        n_bytes = n_bytes + pmks_pkg::OPOS_W'(1);
      end
      pmks_pkg::CMD_END: begin
        if (!top_valid) begin
          b = '0;
          b.last = 1'b1;
          fresh_beats.insert(fresh_beats.size(), b);
        end else begin
          for (int j = 0; j < k; j++) begin
            b.found = 1'b1;
            b.start = top_start;
            b.cost = top_dead ? '0 : top_cost;
            b.dead = top_dead;
            b.ch = top_bytes[j];
            b.last = (j == k - 1);
            fresh_beats.insert(fresh_beats.size(), b);
          end
        end
        clear_scan();
      end
      default: ;
    endcase
  endfunction

  // -------------------------------------------------------------- drivers
  task automatic send_beat(input logic [pmks_pkg::CMD_W-1:0] c,
                           input logic [pmks_pkg::ROW_W-1:0] r,
                           input logic [pmks_pkg::COL_W-1:0] col,
                           input logic [pmks_pkg::ENTRY_W-1:0] e,
                           input logic [pmks_pkg::CHAR_W-1:0] ch, input bit typed,
                           input kmer_beat_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_base_row <= r;
    in_column <= col;
    in_entry_cost <= e;
    in_text_char <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_beat(c, r, col, e, ch);
    if (typed) begin
      fresh_beats.delete();
      kmer_expect_q.insert(kmer_expect_q.size(), want);
    end else begin
      while (fresh_beats.size() != 0)
        kmer_expect_q.insert(kmer_expect_q.size(), fresh_beats.pop_front());
    end
  endtask

  // hold the input off until every expected beat is out, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (kmer_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [pmks_pkg::ENTRY_W-1:0] pick_cost();
    int r;
    r = int'($urandom_range(99));
    if (r < 15) return pmks_pkg::COST_NONE;
    if (r < 25) return pmks_pkg::ENTRY_W'($urandom);
    return pmks_pkg::ENTRY_W'($urandom_range(1023));
  endfunction

  task automatic send_random(input logic [pmks_pkg::CMD_W-1:0] c);
    send_beat(c, pmks_pkg::ROW_W'($urandom), pmks_pkg::COL_W'($urandom), pick_cost(),
              pmks_pkg::CHAR_W'($urandom), 1'b0, '0);
  endtask

  // -------------------------------------------------------------- checker
  function automatic void check_field(input string name,
                                      input logic [pmks_pkg::COST_W-1:0] want,
                                      input logic [pmks_pkg::COST_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  kmer_beat_t mon_want;

  always @(posedge clk) begin
    out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (kmer_expect_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat, expected none, got char %0h", $time,
                 out_window_char);
      end else begin
        mon_want = kmer_expect_q.pop_front();
        check_field("found", pmks_pkg::COST_W'(mon_want.found),
                    pmks_pkg::COST_W'(out_found));
        check_field("start_position", pmks_pkg::COST_W'(mon_want.start),
                    pmks_pkg::COST_W'(out_start_position));
        check_field("best_cost", mon_want.cost, out_best_cost);
        check_field("best_impossible", pmks_pkg::COST_W'(mon_want.dead),
                    pmks_pkg::COST_W'(out_best_impossible));
        check_field("window_char", pmks_pkg::COST_W'(mon_want.ch),
                    pmks_pkg::COST_W'(out_window_char));
        check_field("last", pmks_pkg::COST_W'(mon_want.last),
                    pmks_pkg::COST_W'(out_last));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // -------------------------------------------------------------- stimulus
  dir_row_t dir_rows [22];
  logic [pmks_pkg::CHAR_W-1:0] acgt_set [4];
  logic [pmks_pkg::KCFG_W-1:0] k_plan [N_PHASE];
  int done;
  int len;
  int r;

  initial begin
    acgt_set = '{pmks_pkg::CHAR_A, pmks_pkg::CHAR_C, pmks_pkg::CHAR_G, pmks_pkg::CHAR_T};
    k_plan = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd5, 5'd17, pmks_pkg::KCFG_W'($urandom), 5'd9};
    // k is 1 after reset; column 0 holds the costs that the typed rows rely on
    dir_rows = '{
      '{pmks_pkg::CMD_END, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h00, 1'b1,
        '{1'b0, 16'd0, 20'd0, 1'b0, 8'h00, 1'b1}},
      '{pmks_pkg::CMD_LOAD, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h00, 1'b0, '0},
      '{pmks_pkg::CMD_LOAD, pmks_pkg::ROW_C, 4'd0, pmks_pkg::COST_NONE, 8'h00, 1'b0, '0},
      '{pmks_pkg::CMD_LOAD, pmks_pkg::ROW_G, 4'd0, 16'hFFFE, 8'h00, 1'b0, '0},
      '{pmks_pkg::CMD_LOAD, pmks_pkg::ROW_T, 4'd0, 16'h0100, 8'h00, 1'b0, '0},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, pmks_pkg::CHAR_C, 1'b0, '0},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, pmks_pkg::CHAR_G, 1'b0, '0},
      '{pmks_pkg::CMD_END, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h00, 1'b1,
        '{1'b1, 16'd1, 20'hFFFE, 1'b0, pmks_pkg::CHAR_G, 1'b1}},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, pmks_pkg::CHAR_C, 1'b0, '0},
      '{pmks_pkg::CMD_END, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h00, 1'b1,
        '{1'b1, 16'd0, 20'd0, 1'b1, pmks_pkg::CHAR_C, 1'b1}},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h4E, 1'b0, '0},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, pmks_pkg::CHAR_A, 1'b0, '0},
      '{pmks_pkg::CMD_END, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h00, 1'b1,
        '{1'b1, 16'd1, 20'd0, 1'b0, pmks_pkg::CHAR_A, 1'b1}},
      '{CMD_NOP, pmks_pkg::ROW_T, 4'd15, 16'hFFFF, 8'hFF, 1'b0, '0},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, pmks_pkg::CHAR_T, 1'b0, '0},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, pmks_pkg::CHAR_A, 1'b0, '0},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'hFF, 1'b0, '0},
      '{pmks_pkg::CMD_END, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h00, 1'b1,
        '{1'b1, 16'd2, 20'd0, 1'b0, 8'hFF, 1'b1}},
      '{pmks_pkg::CMD_LOAD, pmks_pkg::ROW_T, 4'd15, pmks_pkg::COST_NONE, 8'h00, 1'b0, '0},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h00, 1'b0, '0},
      '{pmks_pkg::CMD_CHAR, pmks_pkg::ROW_A, 4'd0, 16'h0000, pmks_pkg::CHAR_T, 1'b0, '0},
      '{pmks_pkg::CMD_END, pmks_pkg::ROW_A, 4'd0, 16'h0000, 8'h00, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    k_reg = 5'd1;
    clear_scan();
    for (int i = 0; i < 4*KMAX; i++) prof_cost[i] = '0;
    @(posedge clk);

    // every profile entry is defined before any text beat is scored
    for (int i = 0; i < 4*KMAX; i++)
      send_beat(pmks_pkg::CMD_LOAD, pmks_pkg::ROW_W'(i / KMAX), pmks_pkg::COL_W'(i % KMAX),
                pick_cost(), 8'h00, 1'b0, '0);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].cmd, dir_rows[i].row, dir_rows[i].col, dir_rows[i].cost,
                dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain_results();
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= k_plan[ph];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      k_reg = k_plan[ph];
      clear_scan();
      case (ph % 4)
        0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin send_idle_pct = 61; out_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  out_stall_pct = 61; end
        default: begin send_idle_pct = 26; out_stall_pct = 26; end
      endcase

      done = 0;
      while (done < PHASE_ITEMS) begin
        r = int'($urandom_range(99));
        if (r < 10) begin
          send_random(pmks_pkg::CMD_LOAD);
          done++;
        end else if (r < 15) begin
          send_random(CMD_NOP);
        end else begin
          len = ($urandom_range(9) == 0) ? int'($urandom_range(40))
                                         : int'($urandom_range(eff_k() + 6));
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) send_random(pmks_pkg::CMD_LOAD);
            else if ($urandom_range(6) == 0)
              send_beat(pmks_pkg::CMD_CHAR, pmks_pkg::ROW_W'($urandom),
                        pmks_pkg::COL_W'($urandom), pmks_pkg::ENTRY_W'($urandom),
                        pmks_pkg::CHAR_W'($urandom), 1'b0, '0);
            else
              send_beat(pmks_pkg::CMD_CHAR, pmks_pkg::ROW_W'($urandom),
                        pmks_pkg::COL_W'($urandom), pmks_pkg::ENTRY_W'($urandom),
                        acgt_set[$urandom_range(3)], 1'b0, '0);
            done++;
          end
          send_random(pmks_pkg::CMD_END);
          done++;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && kmer_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
